// File: rtl/assert_macros.svh
// Assertion macros for the knn vote RTL.
// Included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check with async reset disable
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication check
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/knn_pkg.sv
// Shared types and constants for the knn color vote block.
// No dependencies.
package knn_pkg;
  localparam int unsigned CfgW   = 7;
  localparam int unsigned ColorW = 24;
  localparam int unsigned AlphaW = 8;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [0:0] {
    CFG_K     = 1'b0,
    CFG_FLOOR = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_VOTE,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [15:0] x_coord;
    logic [15:0] y_coord;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [1:0]  req_type;
  } req_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } rsp_t;

  // control from sequencer to the sorting chain
  typedef struct packed {
    logic clear;  // drop all entries
    logic shift;  // candidate present this cycle
  } chain_ctl_t;
endpackage

// File: rtl/knn_if.sv
// Valid/ready channel carrying one payload.
// Depends on nothing; payload type set by parameter.
interface knn_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/knn_color_vote_core.sv
// knn_color_vote_core: k-nearest-neighbor color vote over loaded points.
// Clear and load are taken in IDLE. A query (N stored points, u = min(N, k) voters)
//   passes through the scan, chain drain, pairwise vote over the u voters, alpha divide
//   and output states; the result is then registered and held valid until taken.
// One request in flight; the next request is taken only after the result is accepted.
// Reset (async, active low) sets k=8, floor=1 and empties the point store.
module knn_color_vote_core #(
  parameter int unsigned MAX_POINTS    = 1024,
  parameter int unsigned MAX_NEIGHBORS = 64,
  parameter int unsigned COORD_BITS    = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [knn_pkg::CfgW-1:0]   cfg_data_i,
  knn_if.sink                        req_i,
  knn_if.source                      rsp_o
);
  import knn_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned PA    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned PC    = $clog2(MAX_POINTS + 1);
  localparam int unsigned NA    = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int unsigned NC    = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned DW    = COORD_BITS + 1;
  localparam int unsigned DistW = 2 * DW + 1;
  localparam int unsigned DrainW = $clog2(MAX_NEIGHBORS + 4);

  req_t   req;
  state_e state_q, state_d;

  logic [CfgW-1:0] k_cfg_q, fl_q;
  logic [NC-1:0]   k_eff;

  logic [COORD_BITS-1:0] mem_x [MAX_POINTS];
  logic [COORD_BITS-1:0] mem_y [MAX_POINTS];
  logic [ColorW-1:0]     mem_c [MAX_POINTS];
  logic [PC-1:0]         total_q;

  logic [COORD_BITS-1:0] qx_q, qy_q;
  logic [PC-1:0]         rd_cnt_q;
  logic                  rd_vld_q, sq_vld_q;
  logic [COORD_BITS-1:0] rx_q, ry_q;
  logic [ColorW-1:0]     rc_q, sc_q;
  logic [DW-1:0]         dx, dy;
  logic [DistW-1:0]      sq_dist_q;
  logic [DrainW-1:0]     drain_q;

  // chain
  chain_ctl_t            ctl;
  logic [MAX_NEIGHBORS:0] c_vld;
  logic [MAX_NEIGHBORS:0] c_disp;
  logic [DistW-1:0]      c_dist  [MAX_NEIGHBORS+1];
  logic [ColorW-1:0]     c_color [MAX_NEIGHBORS+1];
  logic [MAX_NEIGHBORS-1:0] c_full;
  logic [ColorW-1:0]     slot_color [MAX_NEIGHBORS];

  // vote
  logic [NA-1:0] l_q, j_q;
  logic [NC-1:0] cnt_q, win_cnt_q;
  logic [ColorW-1:0] win_color_q;
  logic [NC-1:0] used;

  // divider
  logic [7+NC:0] rem_q;
  logic [7:0]    quo_q;
  logic [3:0]    div_cnt_q;
  logic [CfgW-1:0] den_q;
  logic [CfgW-1:0] num_diff;
  logic [8+NC:0] div_sh;
  logic          alpha_sel_q;  // 0: divide, special alpha in quo
  rsp_t          rsp_q;
  logic          rsp_vld_q;

  assign req = req_i.data;

  always_comb begin
    if (k_cfg_q == '0) k_eff = NC'(1);
    else if (32'(k_cfg_q) > MAX_NEIGHBORS) k_eff = NC'(MAX_NEIGHBORS);
    else k_eff = NC'(k_cfg_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_cfg_q <= CfgW'(8);
      fl_q    <= CfgW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_K:     k_cfg_q <= cfg_data_i;
        CFG_FLOOR: fl_q    <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  assign req_i.ready = (state_q == ST_IDLE) && !rsp_vld_q;
  logic acc;
  assign acc = req_i.valid && req_i.ready;

  // point memory
  always_ff @(posedge clk_i) begin
    if (acc && req_e'(req.req_type) == REQ_LOAD && 32'(total_q) < MAX_POINTS) begin
      mem_x[total_q[PA-1:0]] <= req.x_coord[COORD_BITS-1:0];
      mem_y[total_q[PA-1:0]] <= req.y_coord[COORD_BITS-1:0];
      mem_c[total_q[PA-1:0]] <= {req.red_in, req.green_in, req.blue_in};
    end
    rx_q <= mem_x[rd_cnt_q[PA-1:0]];
    ry_q <= mem_y[rd_cnt_q[PA-1:0]];
    rc_q <= mem_c[rd_cnt_q[PA-1:0]];
  end

  always_comb begin
    logic signed [DW-1:0] ax, ay;
    ax = DW'($signed(qx_q)) - DW'($signed(rx_q));
    ay = DW'($signed(qy_q)) - DW'($signed(ry_q));
    dx = ax[DW-1] ? DW'(-ax) : DW'(ax);
    dy = ay[DW-1] ? DW'(-ay) : DW'(ay);
  end

  always_ff @(posedge clk_i) begin
    sq_dist_q <= DistW'(dx * dx) + DistW'(dy * dy);
    sc_q      <= rc_q;
  end

  assign ctl.clear = acc && req_e'(req.req_type) == REQ_QUERY;
  assign ctl.shift = sq_vld_q;

  assign c_vld[0]   = sq_vld_q;
  assign c_disp[0]  = 1'b0;
  assign c_dist[0]  = sq_dist_q;
  assign c_color[0] = sc_q;

  for (genvar g = 0; g < MAX_NEIGHBORS; g++) begin : g_cell
    knn_cell #(.DistW(DistW)) u_cell (
      .clk_i, .rst_ni,
      .ctl_i       (ctl),
      .enable_i    (32'(g) < 32'(k_eff)),
      .cand_vld_i  (c_vld[g]),
      .cand_disp_i (c_disp[g]),
      .cand_dist_i (c_dist[g]),
      .cand_color_i(c_color[g]),
      .cand_vld_o  (c_vld[g+1]),
      .cand_disp_o (c_disp[g+1]),
      .cand_dist_o (c_dist[g+1]),
      .cand_color_o(c_color[g+1]),
      .full_o      (c_full[g]),
      .color_o     (slot_color[g])
    );
  end

  assign used = NC'($countones(c_full));

  // main control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      total_q   <= '0;
      rd_cnt_q  <= '0;
      rd_vld_q  <= 1'b0;
      sq_vld_q  <= 1'b0;
      drain_q   <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sq_vld_q <= rd_vld_q;
      rd_vld_q <= (state_q == ST_SCAN) && (rd_cnt_q < total_q);
      if (acc) begin
        unique case (req_e'(req.req_type))
          REQ_CLEAR: total_q <= '0;
          REQ_LOAD:  if (32'(total_q) < MAX_POINTS) total_q <= total_q + PC'(1);
          REQ_QUERY: rd_cnt_q <= '0;
          default:   ;
        endcase
      end
      if (state_q == ST_SCAN && rd_cnt_q < total_q) begin
        rd_cnt_q <= rd_cnt_q + PC'(1);
      end
      if (state_q == ST_SCAN) drain_q <= '0;
      else if (state_q == ST_DRAIN) drain_q <= drain_q + DrainW'(1);
      if (state_q == ST_OUT) rsp_vld_q <= 1'b1;
      else if (rsp_o.ready) rsp_vld_q <= 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (acc && req_e'(req.req_type) == REQ_QUERY) state_d = ST_SCAN;
      ST_SCAN:  if (rd_cnt_q >= total_q) state_d = ST_DRAIN;
      ST_DRAIN: if (32'(drain_q) == MAX_NEIGHBORS + 3) state_d = ST_VOTE;
      ST_VOTE:  if (used == '0 || (NC'(l_q) == used - NC'(1) && j_q == l_q))
                  state_d = ST_DIV;
      ST_DIV:   if (div_cnt_q == 4'd0) state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      qx_q <= req.x_coord[COORD_BITS-1:0];
      qy_q <= req.y_coord[COORD_BITS-1:0];
    end
  end

  // vote: one comparison per cycle, j runs 0..l
  logic eq;
  logic [NC-1:0] cnt_now;
  assign eq      = slot_color[j_q] == slot_color[l_q];
  assign cnt_now = cnt_q + NC'(eq);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DRAIN) begin
      l_q <= '0; j_q <= '0; cnt_q <= '0;
      win_cnt_q <= '0; win_color_q <= '0;
    end else if (state_q == ST_VOTE && used != '0) begin
      if (j_q == l_q) begin
        if (cnt_now > win_cnt_q) begin
          win_cnt_q   <= cnt_now;
          win_color_q <= slot_color[l_q];
        end
        l_q <= l_q + NA'(1); j_q <= '0; cnt_q <= '0;
      end else begin
        j_q <= j_q + NA'(1); cnt_q <= cnt_now;
      end
    end
  end

  assign num_diff = CfgW'(win_cnt_q) - fl_q;
  assign div_sh   = {rem_q, 1'b0};

  // restoring divider: 128*(count-floor)/(k-floor), 8 quotient bits
  always_ff @(posedge clk_i) begin
    if (state_q == ST_VOTE) begin
      den_q     <= CfgW'(k_eff) - fl_q;
      div_cnt_q <= 4'd8;
    end else if (state_q == ST_DIV) begin
      if (div_cnt_q == 4'd8) begin
        div_cnt_q <= 4'd7;
        if (CfgW'(k_eff) == fl_q) begin
          alpha_sel_q <= 1'b1; quo_q <= 8'd128; rem_q <= '0;
        end else if (CfgW'(win_cnt_q) <= fl_q || CfgW'(k_eff) < fl_q) begin
          alpha_sel_q <= 1'b1; quo_q <= 8'd0; rem_q <= '0;
        end else begin
          alpha_sel_q <= 1'b0;
          // top quotient bit is set only when count equals k
          if (num_diff >= den_q) begin
            quo_q <= 8'd1;
            rem_q <= (8+NC)'(num_diff - den_q);
          end else begin
            quo_q <= 8'd0;
            rem_q <= (8+NC)'(num_diff);
          end
        end
      end else if (div_cnt_q != 4'd0) begin
        div_cnt_q <= div_cnt_q - 4'd1;
        if (!alpha_sel_q) begin
          if (div_sh >= (9+NC)'(den_q)) begin
            rem_q <= (8+NC)'(div_sh - (9+NC)'(den_q));
            quo_q <= {quo_q[6:0], 1'b1};
          end else begin
            rem_q <= (8+NC)'(div_sh);
            quo_q <= {quo_q[6:0], 1'b0};
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT) begin
      rsp_q.red_out   <= win_color_q[23:16];
      rsp_q.green_out <= win_color_q[15:8];
      rsp_q.blue_out  <= win_color_q[7:0];
      rsp_q.alpha_out <= quo_q;
    end
  end

  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;

  `ASSERT_IMPL(a_no_accept_busy, state_q != ST_IDLE, !req_i.ready)
  `ASSERT_IMPL(a_total_bound, 1'b1, 32'(total_q) <= MAX_POINTS)
  `ASSERT_NEXT(a_out_valid, state_q == ST_OUT, rsp_vld_q)
  `ASSERT_IMPL(a_used_bound, state_q == ST_VOTE, used <= k_eff)
endmodule

// File: rtl/knn_cell.sv
// One cell of the sorted insertion chain: holds one neighbor slot.
// Depends on knn_pkg.
module knn_cell #(
  parameter int unsigned DistW = 35
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  knn_pkg::chain_ctl_t       ctl_i,
  input  logic                      enable_i,   // this slot exists (below k)
  // candidate traveling down the chain
  input  logic                      cand_vld_i,
  input  logic                      cand_disp_i,  // candidate was pushed out of a slot above
  input  logic [DistW-1:0]          cand_dist_i,
  input  logic [knn_pkg::ColorW-1:0] cand_color_i,
  output logic                      cand_vld_o,
  output logic                      cand_disp_o,
  output logic [DistW-1:0]          cand_dist_o,
  output logic [knn_pkg::ColorW-1:0] cand_color_o,
  output logic                      full_o,
  output logic [knn_pkg::ColorW-1:0] color_o
);
  import knn_pkg::*;

  logic              full_q;
  logic [DistW-1:0]  dist_q;
  logic [ColorW-1:0] color_q;
  logic              take;

  // a new point loses ties; a pushed-out entry is older than anything below it
  assign take = cand_vld_i && enable_i &&
                (!full_q || cand_dist_i < dist_q || (cand_disp_i && cand_dist_i == dist_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q     <= 1'b0;
      cand_vld_o <= 1'b0;
    end else if (ctl_i.clear) begin
      full_q     <= 1'b0;
      cand_vld_o <= 1'b0;
    end else begin
      if (take) full_q <= 1'b1;
      // displaced entry (or passing candidate) moves on
      cand_vld_o <= cand_vld_i && enable_i && (full_q || !take);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      dist_q  <= cand_dist_i;
      color_q <= cand_color_i;
    end
    cand_disp_o <= take || cand_disp_i;
    if (take) begin
      cand_dist_o  <= dist_q;
      cand_color_o <= color_q;
    end else begin
      cand_dist_o  <= cand_dist_i;
      cand_color_o <= cand_color_i;
    end
  end

  assign full_o  = full_q;
  assign color_o = color_q;
endmodule

// File: tb/knn_vote_checker.sv
// Checker for knn_color_vote_core: watches config writes and both channels,
// predicts each query result and compares it field by field.
// Depends on knn_pkg and knn_if.
`timescale 1ns / 1ps
module knn_vote_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [0:0]               cfg_idx_i,
  input  logic [knn_pkg::CfgW-1:0] cfg_data_i,
  knn_if                           req_mon,
  knn_if                           rsp_mon,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);
  import knn_pkg::*;

  localparam int unsigned NumPoints = 1024;
  localparam int unsigned NumNbrs   = 64;

  logic signed [15:0] pt_x [NumPoints];
  logic signed [15:0] pt_y [NumPoints];
  logic [23:0]        pt_rgb [NumPoints];
  int unsigned        pt_total;
  logic [CfgW-1:0]    k_reg;
  logic [CfgW-1:0]    floor_reg;
  rsp_t               expected_colors [$];

  // k nearest by exact squared distance, earlier point wins ties, then vote
  function automatic rsp_t vote_query(logic signed [15:0] qx, logic signed [15:0] qy);
    longint unsigned nbr_dist [NumNbrs];
    logic [23:0]     col [NumNbrs];
    longint          dx, dy;
    longint unsigned d, win_cnt, cnt, k, fl, alpha;
    int unsigned     used, pos;
    logic [23:0]     win_rgb;
    rsp_t            r;
    k = k_reg;
    if (k == 0) k = 1;
    if (k > NumNbrs) k = NumNbrs;
    used = 0;
    for (int unsigned i = 0; i < pt_total; i++) begin
      dx = longint'(qx) - longint'(pt_x[i]);
      dy = longint'(qy) - longint'(pt_y[i]);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      d = dx * dx + dy * dy;
      if (used == k && d >= nbr_dist[used-1]) continue;
      pos = (used < k) ? used : used - 1;
      while (pos > 0 && nbr_dist[pos-1] > d) begin
        nbr_dist[pos] = nbr_dist[pos-1];
        col[pos]      = col[pos-1];
        pos--;
      end
      nbr_dist[pos] = d;
      col[pos]      = pt_rgb[i];
      if (used < k) used++;
    end
    win_cnt = 0;
    win_rgb = '0;
    for (int unsigned l = 0; l < used; l++) begin
      cnt = 0;
      for (int unsigned j = 0; j <= l; j++)
        if (col[j] == col[l]) cnt++;
      if (cnt > win_cnt) begin
        win_cnt = cnt;
        win_rgb = col[l];
      end
    end
    fl = floor_reg;
    if (fl == k) alpha = 128;
    else if (win_cnt <= fl || k < fl) alpha = 0;
    else alpha = (128 * (win_cnt - fl)) / (k - fl);
    r.red_out   = win_rgb[23:16];
    r.green_out = win_rgb[15:8];
    r.blue_out  = win_rgb[7:0];
    r.alpha_out = alpha[7:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_r, got_r;
    req_t rq;
    if (!rst_ni) begin
      k_reg        = 8;
      floor_reg    = 1;
      pt_total     = 0;
      fail_count_o = 0;
      expected_colors.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_e'(cfg_idx_i) == CFG_K) k_reg = cfg_data_i;
        else floor_reg = cfg_data_i;
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got_r = rsp_mon.data;
        if (expected_colors.size() == 0) begin
          $error("result with no pending query: %h", got_r);
          fail_count_o++;
        end else begin
          exp_r = expected_colors.pop_front();
          if (got_r.red_out != exp_r.red_out) begin
            $error("red_out expected %0d got %0d", exp_r.red_out, got_r.red_out);
            fail_count_o++;
          end
          if (got_r.green_out != exp_r.green_out) begin
            $error("green_out expected %0d got %0d", exp_r.green_out, got_r.green_out);
            fail_count_o++;
          end
          if (got_r.blue_out != exp_r.blue_out) begin
            $error("blue_out expected %0d got %0d", exp_r.blue_out, got_r.blue_out);
            fail_count_o++;
          end
          if (got_r.alpha_out != exp_r.alpha_out) begin
            $error("alpha_out expected %0d got %0d", exp_r.alpha_out, got_r.alpha_out);
            fail_count_o++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        rq = req_mon.data;
        case (req_e'(rq.req_type))
          REQ_CLEAR: pt_total = 0;
          REQ_LOAD: begin
            if (pt_total < NumPoints) begin
              pt_x[pt_total]   = rq.x_coord;
              pt_y[pt_total]   = rq.y_coord;
              pt_rgb[pt_total] = {rq.red_in, rq.green_in, rq.blue_in};
              pt_total++;
            end
          end
          REQ_QUERY: expected_colors.push_back(vote_query(rq.x_coord, rq.y_coord));
          default: ;
        endcase
      end
    end
    pending_o = expected_colors.size();
  end
endmodule

// File: tb/tb_knn_color_vote_core.sv
// Top of the knn_color_vote_core testbench: clock, reset, config writes,
// request stimulus and result backpressure. Depends on knn_pkg, knn_if, knn_vote_checker, knn_color_vote_core.
`timescale 1ns / 1ps
module tb_knn_color_vote_core;
  import knn_pkg::*;

  localparam int unsigned IdleLimit = 30000;
  localparam int unsigned SettleCyc = 16;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  logic [0:0]      cfg_idx;
  logic [CfgW-1:0] cfg_data;
  int unsigned     fail_count, pending;
  int unsigned     burst_left, idle_cycles, stall_pct, stall_timer, loaded;
  logic [23:0]     palette [4];
  logic signed [15:0] center_x, center_y;

  knn_if #(.T(req_t)) req_ch ();
  knn_if #(.T(rsp_t)) rsp_ch ();

  knn_color_vote_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  knn_vote_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // receiver: stall rate is redrawn whenever the stall timer runs out, including no stalls
  always @(negedge clk_i) begin
    if (stall_timer == 0) begin
      case ($urandom_range(3))
        0, 1: stall_pct = 0;
        2: stall_pct = 40;
        default: stall_pct = 90;
      endcase
      stall_timer = $urandom_range(80, 10);
    end
    stall_timer--;
    rsp_ch.ready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send(req_t r);
    if (burst_left == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(12)) @(negedge clk_i);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
    end
    req_ch.data  = r;
    req_ch.valid = 1'b1;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
    burst_left--;
    if (r.req_type == REQ_CLEAR) loaded = 0;
    else if (r.req_type == REQ_LOAD) loaded++;
  endtask

  task automatic send_fields(req_e t, int x, int y, logic [23:0] rgb);
    req_t r;
    r.req_type = t;
    r.x_coord  = x[15:0];
    r.y_coord  = y[15:0];
    r.red_in   = rgb[23:16];
    r.green_in = rgb[15:8];
    r.blue_in  = rgb[7:0];
    send(r);
  endtask

  // hold requests until every query result is back, then let loads settle
  task automatic drain();
    req_ch.valid = 1'b0;
    burst_left   = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic set_config(int unsigned k, int unsigned fl);
    drain();
    cfg_we   = 1'b1;
    cfg_idx  = CFG_K;
    cfg_data = k[CfgW-1:0];
    @(negedge clk_i);
    cfg_idx  = CFG_FLOOR;
    cfg_data = fl[CfgW-1:0];
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic send_random();
    req_t        r;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 2 || (loaded > 60 && roll < 12)) r.req_type = REQ_CLEAR;
    else if (roll < 6) r.req_type = REQ_NONE;
    else if (roll < 60) r.req_type = REQ_LOAD;
    else r.req_type = REQ_QUERY;
    if ($urandom_range(4) != 0) begin
      r.x_coord = center_x + $signed(16'($urandom_range(63))) - 16'sd32;
      r.y_coord = center_y + $signed(16'($urandom_range(63))) - 16'sd32;
    end else begin
      r.x_coord = 16'($urandom_range(16'hffff));
      r.y_coord = 16'($urandom_range(16'hffff));
    end
    if ($urandom_range(9) < 7) {r.red_in, r.green_in, r.blue_in} = palette[$urandom_range(3)];
    else {r.red_in, r.green_in, r.blue_in} = 24'($urandom_range(24'hffffff));
    send(r);
  endtask

  task automatic new_scene();
    for (int i = 0; i < 4; i++) palette[i] = 24'($urandom_range(24'hffffff));
    center_x = 16'($urandom_range(16'hffff));
    center_y = 16'($urandom_range(16'hffff));
  endtask

  initial begin
    int unsigned k_list [10]  = '{1, 1, 64, 64, 0, 127, 20, 5, 3, 16};
    int unsigned fl_list [10] = '{0, 1, 64, 0, 0, 127, 70, 2, 1, 4};
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_K;
    cfg_data     = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    burst_left   = 0;
    idle_cycles  = 0;
    stall_pct    = 0;
    stall_timer  = 0;
    loaded       = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty store, coordinate extremes, equal distances, ignored type
    send_fields(REQ_QUERY, 0, 0, '0);
    send_fields(REQ_LOAD, -32768, -32768, 24'h000000);
    send_fields(REQ_LOAD, 32767, 32767, 24'hffffff);
    send_fields(REQ_QUERY, 32767, -32768, '0);
    send_fields(REQ_QUERY, -32768, 32767, '0);
    send_fields(REQ_LOAD, 10, 0, 24'h112233);
    send_fields(REQ_LOAD, -10, 0, 24'h445566);
    send_fields(REQ_LOAD, 0, 10, 24'h445566);
    send_fields(REQ_LOAD, 0, -10, 24'h112233);
    send_fields(REQ_QUERY, 0, 0, '0);
    send_fields(REQ_NONE, 5, 5, 24'haaaaaa);
    send_fields(REQ_QUERY, 32767, 32767, '0);
    send_fields(REQ_CLEAR, 0, 0, '0);
    send_fields(REQ_QUERY, 1, 1, '0);

    // config phases, extremes included, each with a stretch of random traffic
    for (int p = 0; p < 10; p++) begin
      set_config(k_list[p], fl_list[p]);
      new_scene();
      repeat (30) send_random();
    end

    // larger point set with many repeated distances against a full chain
    set_config(64, 10);
    new_scene();
    send_fields(REQ_CLEAR, 0, 0, '0);
    for (int i = 0; i < 150; i++)
      send_fields(REQ_LOAD, center_x + $signed(16'(i % 97)), center_y - $signed(16'(i % 61)),
                  palette[i % 4]);
    send_fields(REQ_QUERY, center_x, center_y, '0);
    send_fields(REQ_QUERY, 32767, -32768, '0);
    set_config(8, 0);
    send_fields(REQ_QUERY, center_x + 16'sd40, center_y - 16'sd20, '0);
    send_fields(REQ_CLEAR, 0, 0, '0);

    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/knn_pkg.sv
rtl/knn_if.sv
rtl/knn_cell.sv
rtl/knn_color_vote_core.sv
tb/knn_vote_checker.sv
tb/tb_knn_color_vote_core.sv
